>>> sv/tssd_pkg.sv
package tssd_pkg;

  localparam int DIST_W  = 16;
  localparam int CODE_W  = 8;
  localparam int TICK_W  = 32;
  localparam int GEST_W  = 3;
  localparam int FLAG_N  = 12;
  localparam int ADDR_W  = 3;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 8;

  // register index taken from the word address bit
  localparam logic REG_MAX_DIST = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  // status codes accepted by the near tests
  localparam logic [CODE_W-1:0] CODE_OK  = 8'd0;
  localparam logic [CODE_W-1:0] CODE_ALT = 8'd7;

  // reset values of the registers
  localparam logic [DIST_W-1:0] MAX_DIST_RST = 16'd300;
  localparam logic [DIST_W-1:0] TIMEOUT_RST  = 16'd1200;

  // item kinds
  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // progress flag positions
  localparam int DU_BOT = 0;
  localparam int DU_MID = 1;
  localparam int DU_TOP = 2;
  localparam int UD_TOP = 3;
  localparam int UD_MID = 4;
  localparam int UD_BOT = 5;
  localparam int LR_L   = 6;
  localparam int LR_M   = 7;
  localparam int LR_R   = 8;
  localparam int RL_R   = 9;
  localparam int RL_M   = 10;
  localparam int RL_L   = 11;

  typedef enum logic [GEST_W-1:0] {
    GEST_NONE = 3'd0,
    GEST_DU   = 3'd1,
    GEST_UD   = 3'd2,
    GEST_LR   = 3'd3,
    GEST_RL   = 3'd4
  } gesture_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_limit;
    logic [DIST_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [DIST_W-1:0] left_distance;
    logic [DIST_W-1:0] center_distance;
    logic [DIST_W-1:0] right_distance;
    logic [CODE_W-1:0] left_code;
    logic [CODE_W-1:0] center_code;
    logic [CODE_W-1:0] right_code;
    logic [TICK_W-1:0] now_ticks;
  } item_t;

  typedef struct packed {
    gesture_t gesture;
    logic     flags_cleared;
  } result_t;

endpackage

>>> sv/three_sensor_swipe_detector_top.sv
// Swipe detector for three distance sensors (left, center, right).
// Input stream: one transfer per item. in_tuser selects the kind: 0 is a
// sensor frame with mean distances and status codes, 1 is a timeout check
// at the tick count in now_ticks. Every item yields exactly one result.
// Output stream: out_tdata carries the gesture code (0 none, 1 down-up,
// 2 up-down, 3 left-right, 4 right-left) and a flag set when a timeout
// check cleared all gesture progress.
// A result passes through the input register and then the result register.
// Throughput: one item per cycle while out_tready is high; the flag update
// is a single short combinational pass between the input and result
// registers. The input register still takes an item while a result waits
// unread, so a stalled receiver holds the result and stops input after one
// more item. Reset (rst_n low, synchronous) clears all progress flags,
// disarms the timeout window, empties both registers and restores the
// distance threshold to 300 and timeout_ticks to 1200. Registers sit at
// byte address 0 and 4 of the configuration port; the user must ensure
// they are written only while idle; the block does not enforce this.
module three_sensor_swipe_detector_top
  import tssd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // fields from bit 0: left_distance, center_distance, right_distance,
  // left_code, center_code, right_code, now_ticks
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // field: mode
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // fields from bit 0: gesture[2:0], flags_cleared[3], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    in_vld_r;
  result_t res;
  result_t res_r;
  logic    out_vld_r;
  logic    fire;

  tssd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // unpack the input transfer
  always_comb begin
    item_nxt.mode            = in_tuser;
    item_nxt.left_distance   = in_tdata[15:0];
    item_nxt.center_distance = in_tdata[31:16];
    item_nxt.right_distance  = in_tdata[47:32];
    item_nxt.left_code       = in_tdata[55:48];
    item_nxt.center_code     = in_tdata[63:56];
    item_nxt.right_code      = in_tdata[71:64];
    item_nxt.now_ticks       = in_tdata[103:72];
  end

  // advance an item into the result register when that slot frees up
  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  tssd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  // result register; hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, res_r.flags_cleared, res_r.gesture};

`ifndef ASSERT_OFF
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.flags_cleared && res_r.gesture != GEST_NONE))
    else $error("result carries both a gesture and a clear");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |=> in_vld_r && $stable(item_r))
    else $error("input register lost an item during a stall");

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed item did not reach the result register");
`endif

endmodule

>>> sv/tssd_cfg.sv
module tssd_cfg
  import tssd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [DIST_W-1:0] max_dist_r;
  logic [DIST_W-1:0] timeout_r;
  logic              wr_en;
  logic              reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  // write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= MAX_DIST_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MAX_DIST: max_dist_r <= cfg_pwdata[DIST_W-1:0];
        REG_TIMEOUT:  timeout_r  <= cfg_pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_MAX_DIST: cfg_prdata = {16'd0, max_dist_r};
      REG_TIMEOUT:  cfg_prdata = {16'd0, timeout_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.dist_limit    = max_dist_r;
  assign cfg.timeout_ticks = timeout_r;

endmodule

>>> sv/tssd_core.sv
module tssd_core
  import tssd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [FLAG_N-1:0] flags_r, flags_nxt;
  logic              armed_r, armed_nxt;
  logic [TICK_W-1:0] start_r, start_nxt;

  logic ln, cn, rn, lf, cf, rf;
  logic lok, cok, rok, lok7, cok7, rok7;
  logic [FLAG_N-1:0] f;
  logic [TICK_W-1:0] start_eff;
  logic [TICK_W-1:0] elapsed;
  logic              expired;
  gesture_t          gest;

  // near and far tests against the threshold
  always_comb begin
    ln   = item.left_distance   < cfg.dist_limit;
    cn   = item.center_distance < cfg.dist_limit;
    rn   = item.right_distance  < cfg.dist_limit;
    lf   = item.left_distance   > cfg.dist_limit;
    cf   = item.center_distance > cfg.dist_limit;
    rf   = item.right_distance  > cfg.dist_limit;
    lok  = item.left_code   == CODE_OK;
    cok  = item.center_code == CODE_OK;
    rok  = item.right_code  == CODE_OK;
    lok7 = lok || (item.left_code   == CODE_ALT);
    cok7 = cok || (item.center_code == CODE_ALT);
    rok7 = rok || (item.right_code  == CODE_ALT);
  end

  // update flags in order; later tests see flags set earlier in the frame
  always_comb begin
    f = flags_r;
    if (ln && lok7 && !f[DU_MID] && !f[DU_TOP] && cf && rf) f[DU_BOT] = 1'b1;
    if (rn && rok7 && !f[DU_MID] && f[DU_BOT] && cf)        f[DU_MID] = 1'b1;
    if (cn && cok7 && f[DU_MID] && f[DU_BOT])               f[DU_TOP] = 1'b1;

    if (cn && cok && !f[UD_MID] && !f[UD_BOT] && lf && rf)  f[UD_TOP] = 1'b1;
    if (rn && rok && !f[UD_BOT] && f[UD_TOP] && lf)         f[UD_MID] = 1'b1;
    if (ln && lok && f[UD_MID] && f[UD_TOP])                f[UD_BOT] = 1'b1;

    if (ln && lok && !f[LR_M] && !f[LR_R] && cf && rf)      f[LR_L] = 1'b1;
    if (cn && cok && !f[LR_R] && f[LR_L] && rf)             f[LR_M] = 1'b1;
    if (rn && rok && f[LR_M] && f[LR_L])                    f[LR_R] = 1'b1;

    if (rn && rok && !f[RL_M] && !f[RL_L] && cf && lf)      f[RL_R] = 1'b1;
    if (cn && cok && !f[RL_L] && f[RL_R] && lf)             f[RL_M] = 1'b1;
    if (ln && lok && f[RL_M] && f[RL_R])                    f[RL_L] = 1'b1;
  end

  // pick the first complete gesture
  always_comb begin
    if (f[DU_BOT] && f[DU_MID] && f[DU_TOP])      gest = GEST_DU;
    else if (f[UD_TOP] && f[UD_MID] && f[UD_BOT]) gest = GEST_UD;
    else if (f[LR_L] && f[LR_M] && f[LR_R])       gest = GEST_LR;
    else if (f[RL_R] && f[RL_M] && f[RL_L])       gest = GEST_RL;
    else                                          gest = GEST_NONE;
  end

  // timeout window; an arming check measures zero elapsed time
  assign start_eff = armed_r ? start_r : item.now_ticks;
  assign elapsed   = item.now_ticks - start_eff;
  assign expired   = elapsed > {{(TICK_W-DIST_W){1'b0}}, cfg.timeout_ticks};

  // next state and result
  always_comb begin
    flags_nxt = flags_r;
    armed_nxt = armed_r;
    start_nxt = start_r;
    res.gesture       = GEST_NONE;
    res.flags_cleared = 1'b0;
    if (item.mode == MODE_CHECK) begin
      start_nxt = start_eff;
      armed_nxt = !expired;
      if (expired) begin
        flags_nxt = '0;
      end
      res.flags_cleared = expired;
    end else begin
      flags_nxt   = f;
      res.gesture = gest;
    end
  end

  // hold state until an item passes through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      armed_r <= 1'b0;
      start_r <= '0;
    end else if (fire) begin
      flags_r <= flags_nxt;
      armed_r <= armed_nxt;
      start_r <= start_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode == MODE_CHECK && expired |=> flags_r == '0 && !armed_r)
    else $error("timeout did not clear flags and disarm");

  a_check_arms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode == MODE_CHECK && !expired |=> armed_r && $stable(flags_r))
    else $error("check without timeout changed flags or left window disarmed");

  a_unarmed_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r && item.mode == MODE_CHECK |-> !expired)
    else $error("arming check reported a timeout");

  a_frame_sets_only: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode == MODE_FRAME |=> (flags_r & $past(flags_r)) == $past(flags_r))
    else $error("sensor frame cleared a progress flag");
`endif

endmodule

>>> sim/three_sensor_swipe_detector_top_tb.sv
module three_sensor_swipe_detector_top_tb;
  import tssd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 230;

  localparam logic [ADDR_W-1:0] ADDR_MAX_DIST = {REG_MAX_DIST, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT  = {REG_TIMEOUT, 2'b00};

  typedef enum int {K_NEAR, K_FAR, K_EQUAL, K_ANY} dist_kind_t;

  // Track gesture progress and hold the results still owed by the block
  class swipe_tracker;
    logic [FLAG_N-1:0] prog;
    logic              armed;
    logic [TICK_W-1:0] win_start;
    logic [DIST_W-1:0] max_dist;
    logic [DIST_W-1:0] tmo;
    result_t           due_results[$];
    int                errors;
    int                checked;
    int                n_gest[5];
    int                n_clear;

    function void reset_state();
      prog      = '0;
      armed     = 1'b0;
      win_start = '0;
      max_dist  = MAX_DIST_RST;
      tmo       = TIMEOUT_RST;
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_item(item_t it);
      result_t           r;
      logic [TICK_W-1:0] elapsed;
      logic              ln, cn, rn, lf, cf, rf;
      logic              lok, cok, rok, lok7, cok7, rok7;
      r.gesture       = GEST_NONE;
      r.flags_cleared = 1'b0;
      if (it.mode == MODE_CHECK) begin
        if (!armed) begin
          armed     = 1'b1;
          win_start = it.now_ticks;
        end
        elapsed = it.now_ticks - win_start;
        if (elapsed > {16'b0, tmo}) begin
          armed           = 1'b0;
          prog            = '0;
          r.flags_cleared = 1'b1;
          n_clear++;
        end
      end else begin
        ln = it.left_distance < max_dist;
        cn = it.center_distance < max_dist;
        rn = it.right_distance < max_dist;
        lf = it.left_distance > max_dist;
        cf = it.center_distance > max_dist;
        rf = it.right_distance > max_dist;
        lok = it.left_code == CODE_OK;
        cok = it.center_code == CODE_OK;
        rok = it.right_code == CODE_OK;
        lok7 = lok || it.left_code == CODE_ALT;
        cok7 = cok || it.center_code == CODE_ALT;
        rok7 = rok || it.right_code == CODE_ALT;

        // flags update in order, later tests see earlier updates
        if (ln && lok7 && !prog[DU_MID] && !prog[DU_TOP] && cf && rf) prog[DU_BOT] = 1'b1;
        if (rn && rok7 && !prog[DU_MID] && prog[DU_BOT] && cf) prog[DU_MID] = 1'b1;
        if (cn && cok7 && prog[DU_MID] && prog[DU_BOT]) prog[DU_TOP] = 1'b1;

        if (cn && cok && !prog[UD_MID] && !prog[UD_BOT] && lf && rf) prog[UD_TOP] = 1'b1;
        if (rn && rok && !prog[UD_BOT] && prog[UD_TOP] && lf) prog[UD_MID] = 1'b1;
        if (ln && lok && prog[UD_MID] && prog[UD_TOP]) prog[UD_BOT] = 1'b1;

        if (ln && lok && !prog[LR_M] && !prog[LR_R] && cf && rf) prog[LR_L] = 1'b1;
        if (cn && cok && !prog[LR_R] && prog[LR_L] && rf) prog[LR_M] = 1'b1;
        if (rn && rok && prog[LR_M] && prog[LR_L]) prog[LR_R] = 1'b1;

        if (rn && rok && !prog[RL_M] && !prog[RL_L] && cf && lf) prog[RL_R] = 1'b1;
        if (cn && cok && !prog[RL_L] && prog[RL_R] && lf) prog[RL_M] = 1'b1;
        if (ln && lok && prog[RL_M] && prog[RL_R]) prog[RL_L] = 1'b1;

        if (prog[DU_BOT] && prog[DU_MID] && prog[DU_TOP]) r.gesture = GEST_DU;
        else if (prog[UD_TOP] && prog[UD_MID] && prog[UD_BOT]) r.gesture = GEST_UD;
        else if (prog[LR_L] && prog[LR_M] && prog[LR_R]) r.gesture = GEST_LR;
        else if (prog[RL_R] && prog[RL_M] && prog[RL_L]) r.gesture = GEST_RL;
        n_gest[r.gesture]++;
      end
      due_results.push_back(r);
    endfunction

    // Compare one output transfer with the oldest owed result
    function void check_result(logic [OUT_DATA_W-1:0] d);
      result_t r;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result gesture %0d cleared %0d", $time, d[2:0], d[3]);
        errors++;
        return;
      end
      r = due_results.pop_front();
      checked++;
      if (d[2:0] !== r.gesture || d[3] !== r.flags_cleared || d[7:4] !== 4'b0) begin
        $display("%0t: mismatch expected gesture %0d cleared %0d, actual tdata %b",
                 $time, r.gesture, r.flags_cleared, d);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]     cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  swipe_tracker      sb;
  logic              idle_on = 1'b1;
  int                stall_left = 0;
  int                idle_cycles = 0;
  int                sent = 0;
  int                checks_sent = 0;
  logic [TICK_W-1:0] ticks;

  three_sensor_swipe_detector_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the receiver in random bursts while idling is enabled
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(7, 0) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(6, 1) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // End the run when transfers stop for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("three_sensor_swipe_detector_top verification failed");
      $finish;
    end
  end

  function automatic logic [DIST_W-1:0] pick_dist(dist_kind_t kind);
    int m;
    m = int'(sb.max_dist);
    if (kind == K_ANY) begin
      case ($urandom_range(5, 0))
        0: kind = K_NEAR;
        1: kind = K_FAR;
        2: kind = K_EQUAL;
        default: return DIST_W'($urandom_range(65535, 0));
      endcase
    end
    case (kind)
      K_NEAR:  return (m == 0) ? '0 : DIST_W'($urandom_range(m - 1, 0));
      K_FAR:   return (m == 65535) ? '1 : DIST_W'($urandom_range(65535, m + 1));
      default: return DIST_W'(m);
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(logic near_side, logic alt_ok);
    int r;
    if (near_side) begin
      r = $urandom_range(9, 0);
      if (r == 0) return CODE_W'($urandom_range(255, 0));
      if (alt_ok && r < 5) return CODE_ALT;
      return CODE_OK;
    end
    case ($urandom_range(3, 0))
      0: return CODE_OK;
      1: return CODE_ALT;
      default: return CODE_W'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic item_t make_frame(dist_kind_t lk, dist_kind_t ck, dist_kind_t rk,
                                       logic alt_ok);
    item_t it;
    it.mode            = MODE_FRAME;
    it.left_distance   = pick_dist(lk);
    it.center_distance = pick_dist(ck);
    it.right_distance  = pick_dist(rk);
    it.left_code       = pick_code(lk == K_NEAR, alt_ok);
    it.center_code     = pick_code(ck == K_NEAR, alt_ok);
    it.right_code      = pick_code(rk == K_NEAR, alt_ok);
    it.now_ticks       = $urandom();
    return it;
  endfunction

  function automatic item_t fixed_frame(logic [DIST_W-1:0] l, logic [DIST_W-1:0] c,
                                        logic [DIST_W-1:0] r, logic [CODE_W-1:0] lc,
                                        logic [CODE_W-1:0] cc, logic [CODE_W-1:0] rc);
    item_t it;
    it.mode            = MODE_FRAME;
    it.left_distance   = l;
    it.center_distance = c;
    it.right_distance  = r;
    it.left_code       = lc;
    it.center_code     = cc;
    it.right_code      = rc;
    it.now_ticks       = $urandom();
    return it;
  endfunction

  // Timeout check; the other fields carry random junk
  function automatic item_t check_at(logic [TICK_W-1:0] t);
    item_t it;
    it           = make_frame(K_ANY, K_ANY, K_ANY, 1'b1);
    it.mode      = MODE_CHECK;
    it.now_ticks = t;
    return it;
  endfunction

  // Drive one item and hold it until the transfer; called at a falling edge
  task automatic send_item(item_t it);
    if (idle_on && $urandom_range(3, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {it.now_ticks, it.right_code, it.center_code, it.left_code,
                  it.right_distance, it.center_distance, it.left_distance};
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
    sent++;
    if (it.mode == MODE_CHECK) checks_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result has come out
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (sb.due_results.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [ADDR_W-1:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write a register, read it back and update the tracker
  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [DIST_W-1:0] val);
    logic [31:0] rd;
    cfg_access(1'b1, addr, {16'b0, val}, rd);
    cfg_access(1'b0, addr, '0, rd);
    if (rd !== {16'b0, val}) begin
      $display("%0t: register readback at %0d expected %0d, actual %0d", $time, addr, val, rd);
      sb.errors++;
    end
    if (addr == ADDR_MAX_DIST) sb.max_dist = val;
    else sb.tmo = val;
  endtask

  // Send three frames that walk one gesture through its flags
  task automatic run_gesture(gesture_t g);
    item_t a, b, c;
    case (g)
      GEST_DU: begin
        a = make_frame(K_NEAR, K_FAR, K_FAR, 1'b1);
        b = make_frame(K_ANY, K_FAR, K_NEAR, 1'b1);
        c = make_frame(K_ANY, K_NEAR, K_ANY, 1'b1);
      end
      GEST_UD: begin
        a = make_frame(K_FAR, K_NEAR, K_FAR, 1'b0);
        b = make_frame(K_FAR, K_ANY, K_NEAR, 1'b0);
        c = make_frame(K_NEAR, K_ANY, K_ANY, 1'b0);
      end
      GEST_LR: begin
        a = make_frame(K_NEAR, K_FAR, K_FAR, 1'b0);
        b = make_frame(K_ANY, K_NEAR, K_FAR, 1'b0);
        c = make_frame(K_ANY, K_ANY, K_NEAR, 1'b0);
      end
      default: begin
        a = make_frame(K_FAR, K_FAR, K_NEAR, 1'b0);
        b = make_frame(K_FAR, K_NEAR, K_ANY, 1'b0);
        c = make_frame(K_NEAR, K_ANY, K_ANY, 1'b0);
      end
    endcase
    send_item(a);
    send_item(b);
    send_item(c);
  endtask

  // Advance the tick count around the timeout and send a check
  task automatic run_check();
    int t;
    t = int'(sb.tmo);
    case ($urandom_range(5, 0))
      0: ticks = ticks + $urandom_range(t, 0);
      1: ticks = ticks + t;
      2: ticks = ticks + t + 1;
      3: ticks = ticks + $urandom_range(200000, 0);
      4: ticks = 32'hFFFF_FFFF - $urandom_range(t, 0);
      default: ticks = $urandom();
    endcase
    send_item(check_at(ticks));
  endtask

  task automatic run_directed();
    // down-up with the alternate status code, then a repeat report
    send_item(check_at(32'd100));
    send_item(fixed_frame(16'd0, 16'hFFFF, 16'hFFFF, CODE_ALT, CODE_OK, CODE_OK));
    send_item(fixed_frame(16'hFFFF, 16'd301, 16'd299, CODE_OK, CODE_OK, CODE_ALT));
    send_item(fixed_frame(16'd301, 16'd0, 16'd301, CODE_OK, CODE_OK, CODE_OK));
    send_item(fixed_frame(16'd300, 16'd300, 16'd300, CODE_OK, CODE_OK, CODE_OK));
    // elapsed equal to the timeout keeps flags, one more tick clears
    send_item(check_at(32'd1300));
    send_item(check_at(32'd1301));
    // up-down
    send_item(fixed_frame(16'd400, 16'd0, 16'd400, CODE_OK, CODE_OK, CODE_OK));
    send_item(fixed_frame(16'd400, 16'd301, 16'd10, CODE_OK, CODE_OK, CODE_OK));
    send_item(fixed_frame(16'd10, 16'd301, 16'd301, CODE_OK, CODE_OK, CODE_OK));
    send_item(check_at(32'd5000));
    send_item(check_at(32'd6201));
    // left-right
    send_item(fixed_frame(16'd0, 16'hFFFF, 16'hFFFF, CODE_OK, CODE_OK, CODE_OK));
    send_item(fixed_frame(16'hFFFF, 16'd299, 16'hFFFF, CODE_OK, CODE_OK, CODE_OK));
    send_item(fixed_frame(16'hFFFF, 16'hFFFF, 16'd0, CODE_OK, CODE_OK, CODE_OK));
    send_item(check_at(32'd7000));
    send_item(check_at(32'd65000));
    // right-left, then bad codes at the distance extremes
    send_item(fixed_frame(16'hFFFF, 16'hFFFF, 16'd0, CODE_OK, CODE_OK, CODE_OK));
    send_item(fixed_frame(16'hFFFF, 16'd0, 16'hFFFF, CODE_OK, CODE_OK, CODE_OK));
    send_item(fixed_frame(16'd0, 16'hFFFF, 16'hFFFF, CODE_OK, CODE_OK, CODE_OK));
    send_item(fixed_frame(16'd0, 16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF));
    send_item(fixed_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    // arm just below the tick wrap and clear just after it
    send_item(check_at(32'hFFFF_FFF0));
    send_item(check_at(32'h0000_0500));
  endtask

  task automatic run_random(int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4, 5: run_gesture(gesture_t'($urandom_range(4, 1)));
        6, 7: run_check();
        8: send_item(make_frame(K_ANY, K_ANY, K_ANY, 1'b1));
        default: send_item(make_frame(K_EQUAL, K_ANY, K_EQUAL, 1'b1));
      endcase
      if ($urandom_range(59, 0) == 0) wait_drain();
    end
  endtask

  initial begin
    logic [DIST_W-1:0] dist_set[PHASES];
    logic [DIST_W-1:0] tmo_set[PHASES];
    sb = new();
    sb.reset_state();
    dist_set = '{16'd300, 16'd0, 16'hFFFF, 16'd0, 16'd500, 16'd1};
    tmo_set  = '{16'd1200, 16'd0, 16'hFFFF, 16'd0, 16'd40, 16'hFFFE};
    dist_set[3] = DIST_W'($urandom_range(2000, 1));
    tmo_set[3]  = DIST_W'($urandom_range(65535, 0));
    ticks = $urandom();

    // hold reset, then release at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drain();
        cfg_write(ADDR_MAX_DIST, dist_set[p]);
        cfg_write(ADDR_TIMEOUT, tmo_set[p]);
      end
      if (p == PHASES - 1) idle_on = 1'b0;
      if (p == 0) run_directed();
      run_random(PHASE_ITEMS);
    end
    wait_drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d items (%0d timeout checks), checked %0d results over %0d settings",
             sent, checks_sent, sb.checked, PHASES);
    $display("Reported DU %0d, UD %0d, LR %0d, RL %0d; timeout clears %0d",
             sb.n_gest[GEST_DU], sb.n_gest[GEST_UD], sb.n_gest[GEST_LR],
             sb.n_gest[GEST_RL], sb.n_clear);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("three_sensor_swipe_detector_top verification clean");
    end else begin
      $display("three_sensor_swipe_detector_top verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/tssd_pkg.sv
sv/tssd_cfg.sv
sv/tssd_core.sv
sv/three_sensor_swipe_detector_top.sv
sim/three_sensor_swipe_detector_top_tb.sv
